>>> hdl/htfd_pkg.sv
package htfd_pkg;

  localparam logic [7:0] CRC_INIT = 8'hFF;
  localparam logic [7:0] CRC_POLY = 8'h31;

  localparam int RAW_W   = 16;
  localparam int TEMP_W  = 10;
  localparam int HUM_W   = 7;

  typedef struct packed {
    logic             ok;
    logic [RAW_W-1:0] temp_word;
    logic [RAW_W-1:0] hum_raw;
  } frame_t;

  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

>>> hdl/htfd_frame.sv
module htfd_frame
  import htfd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_start,
  output logic       fr_valid,
  input  logic       fr_ready,
  output frame_t     fr
);

  typedef enum logic [2:0] {
    POS_T_HI  = 3'd0,
    POS_T_LO  = 3'd1,
    POS_T_CRC = 3'd2,
    POS_H_HI  = 3'd3,
    POS_H_LO  = 3'd4,
    POS_H_CRC = 3'd5
  } pos_t;

  logic       a_valid_r;
  logic [7:0] a_byte_r;
  logic       a_start_r;

  pos_t       pos_r, pos_nxt, pos;
  logic [7:0] crc_r, crc_nxt;
  logic [15:0] temp_r, temp_nxt;
  logic [7:0] hum_hi_r, hum_hi_nxt;
  logic [7:0] hum_lo_r, hum_lo_nxt;
  logic       first_ok_r, first_ok_nxt;

  logic       produces;
  logic       a_ready;
  logic       consume;

  always_comb begin
    pos = pos_r;
    if (a_start_r || pos_r > POS_H_CRC) begin
      pos = POS_T_HI;
    end
  end

  assign produces = (pos == POS_H_CRC);
  assign a_ready  = !a_valid_r || !produces || fr_ready;
  assign consume  = a_valid_r && a_ready;
  assign in_ready = a_ready;

  assign fr_valid     = a_valid_r && produces;
  assign fr.ok        = first_ok_r && (crc_r == a_byte_r);
  assign fr.temp_word = temp_r;
  assign fr.hum_raw   = {hum_hi_r, hum_lo_r};

  always_comb begin
    crc_nxt      = crc_r;
    temp_nxt     = temp_r;
    hum_hi_nxt   = hum_hi_r;
    hum_lo_nxt   = hum_lo_r;
    first_ok_nxt = first_ok_r;
    pos_nxt      = (pos == POS_H_CRC) ? POS_T_HI : pos_t'(pos + 3'd1);
    unique case (pos)
      POS_T_HI: begin
        crc_nxt  = crc8_byte(CRC_INIT, a_byte_r);
        temp_nxt = {a_byte_r, 8'd0};
      end
      POS_T_LO: begin
        crc_nxt  = crc8_byte(crc_r, a_byte_r);
        temp_nxt = {temp_r[15:8], a_byte_r};
      end
      POS_T_CRC: begin
        first_ok_nxt = (crc_r == a_byte_r);
        crc_nxt      = CRC_INIT;
      end
      POS_H_HI: begin
        crc_nxt    = crc8_byte(CRC_INIT, a_byte_r);
        hum_hi_nxt = a_byte_r;
      end
      POS_H_LO: begin
        crc_nxt    = crc8_byte(crc_r, a_byte_r);
        hum_lo_nxt = a_byte_r;
      end
      default: begin
        crc_nxt = CRC_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r  <= 1'b0;
      pos_r      <= POS_T_HI;
      crc_r      <= CRC_INIT;
      temp_r     <= '0;
      hum_hi_r   <= '0;
      hum_lo_r   <= '0;
      first_ok_r <= 1'b0;
    end else begin
      if (a_ready) begin
        a_valid_r <= in_valid;
      end
      if (consume) begin
        pos_r      <= pos_nxt;
        crc_r      <= crc_nxt;
        temp_r     <= temp_nxt;
        hum_hi_r   <= hum_hi_nxt;
        hum_lo_r   <= hum_lo_nxt;
        first_ok_r <= first_ok_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && in_valid) begin
      a_byte_r  <= in_byte;
      a_start_r <= in_start;
    end
  end

endmodule

>>> hdl/htfd_convert.sv
module htfd_convert
  import htfd_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     fr_valid,
  output logic                     fr_ready,
  input  frame_t                   fr,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     out_status,
  output logic signed [TEMP_W-1:0] out_temp,
  output logic [HUM_W-1:0]         out_hum
);

  localparam logic [24:0] TEMP_SPAN = 25'd315;
  localparam logic [24:0] HUM_SPAN  = 25'd100;
  localparam logic signed [TEMP_W-1:0] TEMP_OFFSET = 10'sd49;

  // round(m / 65535): reciprocal estimate, then one correction step
  function automatic logic [8:0] div_round(input logic [24:0] m);
    logic [25:0] y;
    logic [25:0] s;
    logic [9:0]  est;
    logic [25:0] r;
    logic [9:0]  q;
    y   = {1'b0, m} + 26'd32767;
    s   = y + (y >> 16);
    est = s[25:16];
    r   = y - {est, 16'd0} + {16'd0, est};
    q   = (r >= 26'd65535) ? est + 10'd1 : est;
    return q[8:0];
  endfunction

  logic        b_valid_r;
  frame_t      b_r;
  logic        c_valid_r;
  logic        c_ok_r;
  logic [24:0] c_mt_r;
  logic [24:0] c_mh_r;
  logic        o_valid_r;
  logic        o_status_r;
  logic signed [TEMP_W-1:0] o_temp_r;
  logic [HUM_W-1:0] o_hum_r;

  logic b_ready, c_ready, o_ready;
  logic [8:0] tq, hq;

  assign o_ready  = !o_valid_r || out_ready;
  assign c_ready  = !c_valid_r || o_ready;
  assign b_ready  = !b_valid_r || c_ready;
  assign fr_ready = b_ready;

  assign tq = div_round(c_mt_r);
  assign hq = div_round(c_mh_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
      c_valid_r <= 1'b0;
      o_valid_r <= 1'b0;
    end else begin
      if (b_ready) begin
        b_valid_r <= fr_valid;
      end
      if (c_ready) begin
        c_valid_r <= b_valid_r;
      end
      if (o_ready) begin
        o_valid_r <= c_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (b_ready && fr_valid) begin
      b_r <= fr;
    end
    if (c_ready && b_valid_r) begin
      c_ok_r <= b_r.ok;
      c_mt_r <= TEMP_SPAN * {9'd0, b_r.temp_word};
      c_mh_r <= HUM_SPAN * {9'd0, b_r.hum_raw};
    end
    if (o_ready && c_valid_r) begin
      o_status_r <= !c_ok_r;
      o_temp_r   <= c_ok_r ? ($signed({1'b0, tq}) - TEMP_OFFSET) : '0;
      o_hum_r    <= c_ok_r ? hq[HUM_W-1:0] : '0;
    end
  end

  assign out_valid  = o_valid_r;
  assign out_status = o_status_r;
  assign out_temp   = o_temp_r;
  assign out_hum    = o_hum_r;

endmodule

>>> hdl/humidity_temp_frame_decoder.sv
// Decodes the six-byte sensor frame (temperature word, its CRC, humidity word, its CRC),
// one byte per input beat; in_tuser marks the first byte and resynchronizes the count.
// Each word is checked with CRC-8 (poly 0x31, init 0xFF). The sixth byte yields one
// output beat: out_tuser is 1 on a CRC mismatch (data then zero), otherwise out_tdata
// carries round(-49 + 315*raw/65535) degrees Fahrenheit and round(100*raw/65535) percent.
// One byte is taken every cycle while in_tready is high. The last byte of a frame passes
// the input register, frame register, constant multiply, then divide-by-65535 into the
// output register, which raises out_tvalid. Up to four results wait inside before
// in_tready drops; bytes that close no frame keep flowing while a result waits.
module humidity_temp_frame_decoder
  import htfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // frame_byte [7:0]
  input  logic        in_tuser,   // frame_start
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // temp_fahrenheit [9:0], humidity_percent [16:10], zero
  output logic        out_tuser   // status
);

  logic   fr_valid;
  logic   fr_ready;
  frame_t fr;
  logic signed [TEMP_W-1:0] temp;
  logic [HUM_W-1:0] hum;

  htfd_frame u_frame (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_byte  (in_tdata),
    .in_start (in_tuser),
    .fr_valid (fr_valid),
    .fr_ready (fr_ready),
    .fr       (fr)
  );

  htfd_convert u_convert (
    .clk        (clk),
    .rst_n      (rst_n),
    .fr_valid   (fr_valid),
    .fr_ready   (fr_ready),
    .fr         (fr),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_status (out_tuser),
    .out_temp   (temp),
    .out_hum    (hum)
  );

  assign out_tdata = {7'd0, hum, temp};

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == 24'd0)
    else $error("crc error beat carries nonzero data");

  a_hum_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> hum <= 7'd100)
    else $error("humidity above 100 percent");

  a_temp_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> temp >= -10'sd49 && temp <= 10'sd266)
    else $error("temperature out of range");

endmodule

>>> tb/humidity_temp_frame_checker.sv
`timescale 1ns / 100ps

module humidity_temp_frame_checker
  import htfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [23:0] out_tdata,
  input  logic        out_tuser,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic                     crc_bad;
    logic signed [TEMP_W-1:0] temp_f;
    logic [HUM_W-1:0]         hum_pct;
  } reading_t;

  reading_t         readings_due[$];
  logic [2:0]       frame_idx;
  logic [7:0]       word_crc;
  logic [RAW_W-1:0] temp_word;
  logic [7:0]       hum_hi;
  logic [7:0]       hum_lo;
  logic             temp_crc_ok;
  int               fails = 0;

  function automatic logic [7:0] crc_step(input logic [7:0] acc, input logic [7:0] din);
    logic [7:0] r;
    r = acc ^ din;
    repeat (8) r = r[7] ? ((r << 1) ^ CRC_POLY) : (r << 1);
    return r;
  endfunction

  // exact rationals, rounded half away from zero
  function automatic logic signed [TEMP_W-1:0] to_fahrenheit(input logic [RAW_W-1:0] raw);
    longint num;
    longint q;
    num = 315 * longint'(raw) - 49 * 65535;
    if (num >= 0) begin
      q = (2 * num + 65535) / 131070;
    end else begin
      q = -((-2 * num + 65535) / 131070);
    end
    return q[TEMP_W-1:0];
  endfunction

  function automatic logic [HUM_W-1:0] to_percent(input logic [RAW_W-1:0] raw);
    longint q;
    q = (200 * longint'(raw) + 65535) / 131070;
    return q[HUM_W-1:0];
  endfunction

  task automatic flag_mismatch(input string why, input reading_t want, input reading_t got);
    fails++;
    if (fails <= 10) begin
      $display("%0t %s: expected status %0b temp %0d hum %0d,", $realtime, why,
               want.crc_bad, $signed(want.temp_f), want.hum_pct);
      $display("  got status %0b temp %0d hum %0d pad %h",
               got.crc_bad, $signed(got.temp_f), got.hum_pct, out_tdata[23:17]);
    end
  endtask

  always @(posedge clk) begin : watch
    logic [2:0] pos;
    reading_t   want;
    reading_t   got;
    reading_t   fresh;
    if (!rst_n) begin
      readings_due.delete();
      frame_idx   = '0;
      word_crc    = CRC_INIT;
      temp_word   = '0;
      hum_hi      = '0;
      hum_lo      = '0;
      temp_crc_ok = 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.crc_bad = out_tuser;
        got.temp_f  = out_tdata[9:0];
        got.hum_pct = out_tdata[16:10];
        if (readings_due.size() == 0) begin
          want = '0;
          flag_mismatch("result beat with nothing expected", want, got);
        end else begin
          want = readings_due.pop_front();
          if (got.crc_bad != want.crc_bad || got.temp_f != want.temp_f ||
              got.hum_pct != want.hum_pct || out_tdata[23:17] != '0) begin
            flag_mismatch("result beat mismatch", want, got);
          end
        end
      end
      if (in_tvalid && in_tready) begin
        pos = (in_tuser || frame_idx > 3'd5) ? 3'd0 : frame_idx;
        case (pos)
          3'd0: begin
            word_crc  = crc_step(CRC_INIT, in_tdata);
            temp_word = {in_tdata, 8'h00};
          end
          3'd1: begin
            word_crc       = crc_step(word_crc, in_tdata);
            temp_word[7:0] = in_tdata;
          end
          3'd2: begin
            temp_crc_ok = (word_crc == in_tdata);
            word_crc    = CRC_INIT;
          end
          3'd3: begin
            word_crc = crc_step(CRC_INIT, in_tdata);
            hum_hi   = in_tdata;
          end
          3'd4: begin
            word_crc = crc_step(word_crc, in_tdata);
            hum_lo   = in_tdata;
          end
          default: begin
            if (temp_crc_ok && word_crc == in_tdata) begin
              fresh.crc_bad = 1'b0;
              fresh.temp_f  = to_fahrenheit(temp_word);
              fresh.hum_pct = to_percent({hum_hi, hum_lo});
            end else begin
              fresh = '0;
              fresh.crc_bad = 1'b1;
            end
            readings_due.push_back(fresh);
            word_crc = CRC_INIT;
          end
        endcase
        frame_idx = (pos >= 3'd5) ? 3'd0 : pos + 3'd1;
      end
    end
    fail_count <= fails;
    pending    <= readings_due.size();
  end

endmodule

>>> tb/tb_humidity_temp_frame_decoder.sv
`timescale 1ns / 100ps

module tb_humidity_temp_frame_decoder
  import htfd_pkg::*;
();

  localparam int ITEM_TARGET    = 950;
  localparam int CYCLE_LIMIT    = 400000;
  localparam int SQUEEZE_CYCLES = 400;
  localparam int SETTLE_CYCLES  = 10;

  localparam logic [1:0] BAD_NONE = 2'd0;
  localparam logic [1:0] BAD_TEMP = 2'd1;
  localparam logic [1:0] BAD_HUM  = 2'd2;
  localparam logic [1:0] BAD_BOTH = 2'd3;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;
  logic        out_tuser;
  int          fail_count;
  int          pending;

  int items_sent = 0;
  int cycles     = 0;
  bit squeeze_req  = 1'b0;
  bit squeeze_done = 1'b0;
  bit no_gaps      = 1'b0;
  bit calm         = 1'b0;
  bit aligned      = 1'b0;

  humidity_temp_frame_decoder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  humidity_temp_frame_checker checker_i (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .fail_count(fail_count),
    .pending   (pending)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic int pick_gap(input bit quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 65) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end else begin
      return $urandom_range(10, 40);
    end
  endfunction

  function automatic logic [15:0] pick_raw();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h0001;
      3: return 16'hFFFE;
      4: return 16'h8000;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic first);
    int gap;
    gap = pick_gap(no_gaps || calm);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= first;
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  // len below six leaves a partial frame behind
  task automatic send_frame(input logic [15:0] t_raw, input logic [15:0] h_raw,
                            input logic [1:0] bad, input logic with_start, input int len);
    logic [7:0] fb [6];
    fb[0] = t_raw[15:8];
    fb[1] = t_raw[7:0];
    fb[2] = crc8_byte(crc8_byte(CRC_INIT, fb[0]), fb[1]);
    fb[3] = h_raw[15:8];
    fb[4] = h_raw[7:0];
    fb[5] = crc8_byte(crc8_byte(CRC_INIT, fb[3]), fb[4]);
    if ((bad & BAD_TEMP) != 0) fb[2] ^= 8'($urandom_range(1, 255));
    if ((bad & BAD_HUM) != 0) fb[5] ^= 8'($urandom_range(1, 255));
    for (int i = 0; i < len; i++) begin
      send_byte(fb[i], with_start && i == 0);
    end
    aligned = (len == 6);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin : ready_side
    int  hold_left;
    int  span;
    bit  ready_calm;
    hold_left  = 0;
    span       = 0;
    ready_calm = 1'b0;
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (span == 0) begin
        span       = $urandom_range(50, 300);
        ready_calm = ($urandom_range(0, 3) == 0);
      end
      span--;
      if (squeeze_req && !squeeze_done) begin
        squeeze_done = 1'b1;
        hold_left    = SQUEEZE_CYCLES;
      end else if (hold_left == 0 && !ready_calm && $urandom_range(0, 99) < 20) begin
        hold_left = pick_gap(1'b0);
      end
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else begin
        out_tready <= 1'b1;
      end
      @(posedge clk);
    end
  end

  initial begin : stimulus
    int         choice;
    logic [1:0] bad;
    in_tvalid <= 1'b0;
    in_tdata  <= 8'h00;
    in_tuser  <= 1'b0;
    rst_n     <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_frame(16'h0000, 16'h0000, BAD_NONE, 1'b1, 6);
    send_frame(16'hFFFF, 16'hFFFF, BAD_NONE, 1'b0, 6);
    send_frame(16'h6666, 16'h8000, BAD_TEMP, 1'b1, 6);
    send_frame(16'hA5A5, 16'h5A5A, BAD_NONE, 1'b1, 2);
    send_frame(16'h1234, 16'hFFFF, BAD_HUM, 1'b1, 6);
    drain();

    while (items_sent < ITEM_TARGET) begin
      calm = ($urandom_range(0, 4) == 0);
      if (!squeeze_req && items_sent >= ITEM_TARGET / 3) begin
        // back-to-back frames against a stalled receiver
        squeeze_req = 1'b1;
        no_gaps     = 1'b1;
        repeat (12) send_frame(pick_raw(), pick_raw(), BAD_NONE, 1'b1, 6);
        no_gaps = 1'b0;
      end else begin
        choice = $urandom_range(0, 99);
        if (choice < 78) begin
          bad = ($urandom_range(0, 99) < 85) ? BAD_NONE : 2'($urandom_range(BAD_TEMP, BAD_BOTH));
          send_frame(pick_raw(), pick_raw(), bad, !aligned || $urandom_range(0, 2) == 0, 6);
        end else if (choice < 88) begin
          send_frame(pick_raw(), pick_raw(), BAD_NONE, 1'b1, $urandom_range(1, 5));
        end else begin
          repeat ($urandom_range(1, 6)) begin
            send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
          end
          aligned = 1'b0;
        end
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
